/* src/rcfd_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcfd_pkg - shared types and constants of the RC receiver frame decoder
// Frame layout, header bytes, result field offsets and the frame record
// passed from the byte decoder to the result emitter.
// ----------------------------------------------------------------------------
package rcfd_pkg;

    localparam int BYTE_W   = 8;
    localparam int CHAN_W   = 16;
    localparam int POS_W    = 5;
    localparam int NUM_CH   = 14;
    localparam int CH_IDX_W = 4;

    // Result beat layout in m_tdata, lowest bit first
    localparam int OUT_IDX_LSB = 0;
    localparam int OUT_VAL_LSB = OUT_IDX_LSB + CH_IDX_W;
    localparam int OUT_HDR_BIT = OUT_VAL_LSB + CHAN_W;
    localparam int OUT_CK_BIT  = OUT_HDR_BIT + 1;
    localparam int OUT_USED_W  = OUT_CK_BIT + 1;
    localparam int OUT_DATA_W  = ((OUT_USED_W + 7) / 8) * 8;

    // Byte positions within a frame
    localparam logic [POS_W-1:0] POS_HDR0     = 5'd0;
    localparam logic [POS_W-1:0] POS_HDR1     = 5'd1;
    localparam logic [POS_W-1:0] POS_FIRST_HI = 5'd3;
    localparam logic [POS_W-1:0] POS_CK_LO    = 5'd30;
    localparam logic [POS_W-1:0] POS_CK_HI    = 5'd31;

    localparam logic [BYTE_W-1:0]   HDR0_BYTE = 8'h20;
    localparam logic [BYTE_W-1:0]   HDR1_BYTE = 8'h40;
    localparam logic [CH_IDX_W-1:0] LAST_CH   = 4'(NUM_CH - 1);

    // Snapshot of one finished frame
    typedef struct packed {
        logic                           header_ok;
        logic                           checksum_ok;
        logic [NUM_CH-1:0][CHAN_W-1:0]  values;
    } rcfd_frame_t;

endpackage

/* src/rc_receiver_frame_decoder.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rc_receiver_frame_decoder - fixed 32-byte RC receiver frame decoder
// Accepts one byte per beat, tracks header, checksum and channel values,
// and emits the 14 stored channels at the end of each frame.
// ----------------------------------------------------------------------------
// Throughput: one byte per cycle, except while a frame-end byte waits for the emitter;
//   a frame's 14 results leave one per cycle while m_tready is high.
// Path: a frame's last byte passes the input register, the snapshot register and
//   the output register; a frame-end byte stalls only while the previous frame's results are still draining.
// Reset: synchronous on aresetn low; frame position, checksum, header flags
//   and all channel values return to zero, and no result is pending.
module rc_receiver_frame_decoder
    import rcfd_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [BYTE_W-1:0]      s_tdata,   // [7:0] data_byte
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // [3:0] channel_index, [19:4] channel_value, [20] header_ok,
    // [21] checksum_ok, [23:22] zero
    output logic [OUT_DATA_W-1:0]  m_tdata,
    output logic                   m_tlast    // last_of_frame
);

    logic         frame_valid;
    logic         frame_ready;
    rcfd_frame_t  frame;

    rcfd_decode u_decode (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .frame_valid_o (frame_valid),
        .frame_ready_i (frame_ready),
        .frame_o       (frame)
    );

    rcfd_emit u_emit (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .frame_valid_i (frame_valid),
        .frame_ready_o (frame_ready),
        .frame_i       (frame),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tlast       (m_tlast)
    );

endmodule

/* src/rcfd_decode.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcfd_decode - byte register and frame decoder
// Registers each input beat, counts it into its 32-byte frame, checks the
// header, accumulates the checksum and updates the stored channel values.
// ----------------------------------------------------------------------------
module rcfd_decode
    import rcfd_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [BYTE_W-1:0]  s_tdata,
    output logic               frame_valid_o,
    input  logic               frame_ready_i,
    output rcfd_frame_t        frame_o
);

    logic                           in_valid_reg, in_valid_next;
    logic [BYTE_W-1:0]              in_byte_reg;
    logic [POS_W-1:0]               pos_reg, pos_next;
    logic [CHAN_W-1:0]              sum_reg, sum_next;
    logic                           first_hdr_reg, first_hdr_next;
    logic                           hdr_reg, hdr_next;
    logic [BYTE_W-1:0]              low_reg, low_next;
    logic [BYTE_W-1:0]              ck_low_reg, ck_low_next;
    logic [NUM_CH-1:0][CHAN_W-1:0]  chan_reg, chan_next;
    logic                           consume;
    logic [POS_W-1:0]               ch_off;
    logic [CH_IDX_W-1:0]            ch_idx;
    logic                           is_hi_byte;

    // Hold the frame-end beat until the emitter can take a snapshot
    assign consume  = in_valid_reg && ((pos_reg != POS_CK_HI) || frame_ready_i);
    assign s_tready = !in_valid_reg || consume;

    assign ch_off     = pos_reg - POS_FIRST_HI;
    assign ch_idx     = ch_off[CH_IDX_W:1];
    assign is_hi_byte = pos_reg[0] && (pos_reg inside {[POS_FIRST_HI : POS_CK_LO - 5'd1]});

    // Frame decode of the registered beat
    always_comb begin
        in_valid_next  = s_tready ? s_tvalid : in_valid_reg;
        pos_next       = pos_reg;
        sum_next       = sum_reg;
        first_hdr_next = first_hdr_reg;
        hdr_next       = hdr_reg;
        low_next       = low_reg;
        ck_low_next    = ck_low_reg;
        chan_next      = chan_reg;
        if (consume) begin
            pos_next = (pos_reg == POS_CK_HI) ? POS_HDR0 : pos_reg + 5'd1;
            if (pos_reg < POS_CK_LO) begin
                sum_next = sum_reg + CHAN_W'(in_byte_reg);
            end
            case (pos_reg)
                POS_HDR0: begin
                    sum_next       = CHAN_W'(in_byte_reg);
                    first_hdr_next = (in_byte_reg == HDR0_BYTE);
                end
                POS_HDR1: begin
                    hdr_next = first_hdr_reg && (in_byte_reg == HDR1_BYTE);
                end
                POS_CK_LO: begin
                    ck_low_next = in_byte_reg;
                end
                POS_CK_HI: begin
                end
                default: begin
                    if (is_hi_byte) begin
                        if (hdr_reg) begin
                            chan_next[ch_idx] = {in_byte_reg, low_reg};
                        end
                    end else begin
                        low_next = in_byte_reg;
                    end
                end
            endcase
        end
    end

    // Frame record, valid on the consumed last beat
    assign frame_valid_o         = consume && (pos_reg == POS_CK_HI);
    assign frame_o.header_ok     = hdr_reg;
    assign frame_o.checksum_ok   = ({in_byte_reg, ck_low_reg} == ~sum_reg);
    assign frame_o.values        = chan_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            pos_reg       <= POS_HDR0;
            sum_reg       <= '0;
            first_hdr_reg <= 1'b0;
            hdr_reg       <= 1'b0;
            low_reg       <= '0;
            ck_low_reg    <= '0;
            chan_reg      <= '0;
        end else begin
            in_valid_reg  <= in_valid_next;
            pos_reg       <= pos_next;
            sum_reg       <= sum_next;
            first_hdr_reg <= first_hdr_next;
            hdr_reg       <= hdr_next;
            low_reg       <= low_next;
            ck_low_reg    <= ck_low_next;
            chan_reg      <= chan_next;
        end
    end

    // Load the input register whenever it frees up
    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_byte_reg <= s_tdata;
        end
    end

    // A snapshot is only offered when the emitter has room
    a_frame_room: assert property (@(posedge aclk) disable iff (!aresetn)
        frame_valid_o |-> frame_ready_i)
        else $error("frame offered while emitter busy");

    // A stalled beat stays in the input register
    a_beat_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !consume) |=> (in_valid_reg && $stable(in_byte_reg)))
        else $error("stalled beat lost");

    // Frame end falls only on the last position
    a_frame_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        frame_valid_o |=> (pos_reg == POS_HDR0))
        else $error("frame end did not wrap position");

endmodule

/* src/rcfd_emit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcfd_emit - result emitter
// Holds a snapshot of a finished frame and sends its 14 channel results
// through a registered output stage, one per beat.
// ----------------------------------------------------------------------------
module rcfd_emit
    import rcfd_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   frame_valid_i,
    output logic                   frame_ready_o,
    input  rcfd_frame_t            frame_i,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_DATA_W-1:0]  m_tdata,
    output logic                   m_tlast
);

    logic [NUM_CH-1:0][CHAN_W-1:0]  buf_val_reg;
    logic                           buf_hdr_reg;
    logic                           buf_ck_reg;
    logic                           busy_reg, busy_next;
    logic [CH_IDX_W-1:0]            idx_reg, idx_next;
    logic                           m_valid_reg, m_valid_next;
    logic [CH_IDX_W-1:0]            m_idx_reg;
    logic [CHAN_W-1:0]              m_val_reg;
    logic                           m_hdr_reg;
    logic                           m_ck_reg;
    logic                           m_last_reg;
    logic                           out_load;
    logic                           frame_load;

    assign frame_ready_o = !busy_reg;
    assign frame_load    = frame_valid_i && !busy_reg;
    assign out_load      = busy_reg && (!m_valid_reg || m_tready);

    // Advance through the snapshot one channel per free output slot
    always_comb begin
        busy_next    = busy_reg;
        idx_next     = idx_reg;
        m_valid_next = m_valid_reg;
        if (m_tready) begin
            m_valid_next = 1'b0;
        end
        if (frame_load) begin
            busy_next = 1'b1;
            idx_next  = '0;
        end
        if (out_load) begin
            m_valid_next = 1'b1;
            idx_next     = idx_reg + 4'd1;
            if (idx_reg == LAST_CH) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg    <= 1'b0;
            idx_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            busy_reg    <= busy_next;
            idx_reg     <= idx_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Capture the snapshot and load the output register
    always_ff @(posedge aclk) begin
        if (frame_load) begin
            buf_val_reg <= frame_i.values;
            buf_hdr_reg <= frame_i.header_ok;
            buf_ck_reg  <= frame_i.checksum_ok;
        end
        if (out_load) begin
            m_idx_reg  <= idx_reg;
            m_val_reg  <= buf_val_reg[idx_reg];
            m_hdr_reg  <= buf_hdr_reg;
            m_ck_reg   <= buf_ck_reg;
            m_last_reg <= (idx_reg == LAST_CH);
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tlast  = m_last_reg;
    assign m_tdata  = {(OUT_DATA_W - OUT_USED_W)'(0), m_ck_reg, m_hdr_reg, m_val_reg, m_idx_reg};

    // The last beat of a frame always reports the top channel
    a_last_idx: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_last_reg) |-> (m_idx_reg == LAST_CH))
        else $error("tlast on wrong channel");

    // Snapshot index never runs past the channel count
    a_idx_range: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> (idx_reg <= LAST_CH))
        else $error("snapshot index out of range");

    // Emission always starts at channel zero
    a_first_idx: assert property (@(posedge aclk) disable iff (!aresetn)
        frame_load |=> (busy_reg && (idx_reg == '0)))
        else $error("emission did not restart at channel zero");

endmodule
